### hw/rtl/sliding_window_rate_limiter_assert.svh
// Assertion macros shared by the rate limiter's checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef SLIDING_WINDOW_RATE_LIMITER_ASSERT_SVH
`define SLIDING_WINDOW_RATE_LIMITER_ASSERT_SVH

// Same-cycle implication, checked on the rising edge outside reset.
`define SWRL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rate limiter assertion failed");

// Next-cycle implication, checked on the rising edge outside reset.
`define SWRL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rate limiter assertion failed");

`endif

### hw/rtl/swrl_pkg.sv
// Shared types and constants of the sliding window rate limiter.
// Depends on nothing; used by the controller, the datapath and the top level.
`default_nettype none

package swrl_pkg;

	localparam int STAMP_W   = 32;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int EVENTS_W  = 7;

	localparam logic [CFG_W-1:0] WINDOW_RESET = 16'd60;
	localparam logic [CFG_W-1:0] LIMIT_RESET  = 16'd60;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW = 2'd0,
		REG_LIMIT  = 2'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;   // capture the request time and rewind the scan pointers
		logic scan;    // step the read pointer through the log
		logic commit;  // append if allowed, update the count, load the result
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_done;
	} sts_t;

endpackage

`default_nettype wire

### hw/rtl/swrl_ctrl.sv
// Controller of the rate limiter: sequences accept, log compaction and commit.
// Depends on swrl_pkg; drives the datapath through cmd_t and reads sts_t.
`default_nettype none

module swrl_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  wire logic          out_stall,
	input  swrl_pkg::sts_t     sts,
	output swrl_pkg::cmd_t     cmd
);
	import swrl_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.scan_done) begin
					state_nxt = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall   = 1'b1;
		cmd.start  = 1'b0;
		cmd.scan   = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall  = 1'b0;
				cmd.start = in_valid;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			ST_COMMIT: begin
				cmd.commit = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/swrl_dp.sv
// Datapath of the rate limiter: configuration, stamp log memory, compaction
// and result registers. Depends on swrl_pkg; commanded by swrl_ctrl.
`default_nettype none

module swrl_dp #(
	parameter int MAX_EVENTS = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [swrl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [swrl_pkg::CFG_W-1:0]        cfg_wdata,
	input  wire logic [swrl_pkg::STAMP_W-1:0]      now_seconds,
	input  swrl_pkg::cmd_t                         cmd,
	output swrl_pkg::sts_t                         sts,
	output logic                                   admitted,
	output logic [swrl_pkg::EVENTS_W-1:0]          events_in_window
);
	import swrl_pkg::*;

	localparam int CW = $clog2(MAX_EVENTS + 1);
	localparam int AW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;

	logic [CFG_W-1:0]   window_q;
	logic [CFG_W-1:0]   limit_q;
	logic [STAMP_W-1:0] now_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      rd_q;
	logic [CW-1:0]      wr_q;
	logic               rvalid_s1;
	logic [STAMP_W-1:0] rdata_s1;
	logic               admitted_q;
	logic [EVENTS_W-1:0] events_q;

	logic [STAMP_W-1:0] stamp_mem [MAX_EVENTS];

	logic [STAMP_W-1:0] age;
	logic               keep;
	logic               issue;
	logic               ok;
	logic [CW-1:0]      new_count;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [STAMP_W-1:0] mem_wdata;

	// A negative age (a stamp ahead of now, or one so old that the difference wrapped) still counts.
	assign age  = now_q - rdata_s1;
	assign keep = age[STAMP_W-1] || (age < {{(STAMP_W-CFG_W){1'b0}}, window_q});

	assign issue         = cmd.scan && (rd_q < count_q);
	assign sts.scan_done = (rd_q == count_q) && !rvalid_s1;

	assign ok        = (CFG_W'(wr_q) < limit_q) && (wr_q < CW'(MAX_EVENTS));
	assign new_count = wr_q + CW'(ok);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wr_q[AW-1:0];
		mem_wdata = rdata_s1;
		if (rvalid_s1) begin
			mem_we = keep;
		end else if (cmd.commit) begin
			mem_we    = ok;
			mem_wdata = now_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			stamp_mem[mem_waddr] <= mem_wdata;
		end
		rdata_s1 <= stamp_mem[rd_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q  <= WINDOW_RESET;
			limit_q   <= LIMIT_RESET;
			count_q   <= '0;
			rd_q      <= '0;
			wr_q      <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_WINDOW: begin
						window_q <= cfg_wdata;
					end
					REG_LIMIT: begin
						limit_q <= cfg_wdata;
					end
					default: begin
					end
				endcase
			end
			rvalid_s1 <= issue;
			if (cmd.start) begin
				rd_q <= '0;
				wr_q <= '0;
			end else begin
				if (issue) begin
					rd_q <= rd_q + CW'(1);
				end
				if (rvalid_s1 && keep) begin
					wr_q <= wr_q + CW'(1);
				end
			end
			if (cmd.commit) begin
				count_q <= new_count;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			now_q <= now_seconds;
		end
		if (cmd.commit) begin
			admitted_q <= ok;
			events_q   <= EVENTS_W'(new_count);
		end
	end

	assign admitted         = admitted_q;
	assign events_in_window = events_q;

endmodule

`default_nettype wire

### hw/rtl/sliding_window_rate_limiter.sv
// Top level of the sliding window log rate limiter.
// Depends on swrl_pkg, swrl_ctrl and swrl_dp.
//
// Usage: each request item on the input channel carries now_seconds. The
// block keeps a log of the stamps of admitted requests. For each item it
// first drops every logged stamp whose signed age (now minus stamp) is not
// below window_seconds, keeping the order of the rest, then admits and logs
// the request if the remaining count is below both limit_per_window and the
// log capacity MAX_EVENTS. One result item follows each request item with
// the admit flag and the number of stamps in the log afterwards.
// Timing: the compaction reads the log through one registered memory read
// port, one stamp per cycle, and the result is loaded into the output
// register at the commit step once the scan is done. A new request is
// accepted only after the previous item has committed, and in_stall is
// high while an item is in work.
// Output: the result sits in an output register; while the receiver holds
// out_stall the result stays put, and a finished item waits in its commit
// step until the register frees up, with nothing lost.
// Reset: arst_n clears the log count, the control state and the output
// valid, and loads both configuration registers with 60. The log memory is
// not cleared, since only entries below the count are ever used.
// The user writes configuration through cfg_we, cfg_index and cfg_wdata only
// while the block is idle (not enforced by the block); spare indexes are ignored.
`default_nettype none

module sliding_window_rate_limiter #(
	parameter int MAX_EVENTS = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [swrl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [swrl_pkg::CFG_W-1:0]        cfg_wdata,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [swrl_pkg::STAMP_W-1:0]      now_seconds,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   admitted,
	output logic [swrl_pkg::EVENTS_W-1:0]          events_in_window
);
	import swrl_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// The controller walks accept, scan and commit; the datapath owns the
	// configuration, the log and the result registers and answers with the end of the scan.
	swrl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	swrl_dp #(
		.MAX_EVENTS (MAX_EVENTS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.now_seconds      (now_seconds),
		.cmd              (cmd),
		.sts              (sts),
		.admitted         (admitted),
		.events_in_window (events_in_window)
	);

endmodule

`default_nettype wire

### hw/rtl/swrl_chk.sv
// Port-level checker of the rate limiter, bound to the top level below.
// Depends on sliding_window_rate_limiter_assert.svh for the assertion macros.
`default_nettype none

`include "sliding_window_rate_limiter_assert.svh"

module swrl_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic       admitted,
	input wire logic [6:0] events_in_window
);

	logic [7:0] result_bits;

	assign result_bits = {admitted, events_in_window};

	// An accepted item keeps the input closed while its log is compacted.
	`SWRL_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)

	// A new result only appears while an item is in work.
	`SWRL_ASSERT_IMPL(a_result_from_item, clk, arst_n, $rose(out_valid), $past(in_stall))

	// A stalled result holds its payload.
	`SWRL_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(result_bits))

endmodule

bind sliding_window_rate_limiter swrl_chk u_swrl_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_stall         (in_stall),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.admitted         (admitted),
	.events_in_window (events_in_window)
);

`default_nettype wire

### bench/tb_sliding_window_rate_limiter.sv
// Self-checking testbench for the sliding window log rate limiter.
// Depends on swrl_pkg and sliding_window_rate_limiter; runs directed cases, then random traffic
// under several register settings with random idling on both channels.
`default_nettype none

module tb_sliding_window_rate_limiter;
	timeunit 1ns;
	timeprecision 1ps;

	import swrl_pkg::*;

	// Log capacity of the instance, and a cycle budget for the whole run.
	localparam int LOG_DEPTH   = 64;
	localparam int CYCLE_LIMIT = 1000000;

	// Register indexes that hold no register; writes to them must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	// One result item as the block reports it.
	typedef struct packed {
		logic                admitted;
		logic [EVENTS_W-1:0] events;
	} verdict_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;
	logic                 in_valid;
	logic                 in_stall;
	logic [STAMP_W-1:0]   now_seconds;
	logic                 out_valid;
	logic                 out_stall;
	logic                 admitted;
	logic [EVENTS_W-1:0]  events_in_window;

	// Our own copy of the block's state: the admitted stamps in log order and
	// the two configuration registers.
	logic [STAMP_W-1:0] stamp_log[$];
	logic [CFG_W-1:0]   window_cfg;
	logic [CFG_W-1:0]   limit_cfg;

	// Verdicts predicted for accepted requests, oldest first.
	verdict_t pending_verdicts[$];

	int  fail_count;
	int  cycle_count;
	bit  idle_enabled;

	sliding_window_rate_limiter #(
		.MAX_EVENTS(LOG_DEPTH)
	) DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.now_seconds     (now_seconds),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.admitted        (admitted),
		.events_in_window(events_in_window)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Compacts the log for a request at time t and decides on admission. A
	// stamp survives when its age, read as a signed 32-bit value, is negative
	// (a stamp in the future, or one so old that the difference wrapped) or
	// is below the window.
	function automatic verdict_t predict_admission(input logic [STAMP_W-1:0] t);
		logic [STAMP_W-1:0] kept[$];
		logic [STAMP_W-1:0] age;
		verdict_t           v;
		foreach (stamp_log[i]) begin
			age = t - stamp_log[i];
			if (age[STAMP_W-1] || age < {16'd0, window_cfg})
				kept.push_back(stamp_log[i]);
		end
		stamp_log = kept;
		// Both the programmed limit and the store capacity bound admissions.
		v.admitted = (stamp_log.size() < int'(limit_cfg)) && (stamp_log.size() < LOG_DEPTH);
		if (v.admitted)
			stamp_log.push_back(t);
		v.events = EVENTS_W'(stamp_log.size());
		return v;
	endfunction

	// Writes one register. Only called while the block is idle. The enable is
	// lowered after the edge that takes the write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			REG_WINDOW: window_cfg = data;
			REG_LIMIT:  limit_cfg  = data;
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Offers one request item and returns at the edge that accepted it. A
	// random gap may come first; valid otherwise stays high from the previous
	// item, so back-to-back offers never lower and raise it in one step.
	task automatic send_request(input logic [STAMP_W-1:0] t);
		int gap;
		gap = (idle_enabled && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		now_seconds <= t;
		do @(posedge clk); while (in_stall);
		pending_verdicts.push_back(predict_admission(t));
	endtask

	// Holds the sender off until every predicted verdict has come back, then
	// waits for the block to settle into its idle state.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// After reset both registers hold 60. Stamps age out exactly when their
	// age reaches the window.
	task automatic test_reset_values();
		send_request(32'd0);
		send_request(32'd30);
		send_request(32'd59);
		send_request(32'd60);
		send_request(32'd119);
		send_request(32'd120);
		drain_results();
	endtask

	// Stamps in the future are kept, ages of 2^31 or more wrap negative and
	// are kept, and time itself wraps from all ones to zero.
	task automatic test_future_and_wraparound();
		write_reg(REG_WINDOW, 16'd100);
		write_reg(REG_LIMIT, 16'd8);
		send_request(32'd1000);
		send_request(32'd940);
		send_request(32'h8000_0000 + 32'd1000);
		send_request(32'hFFFF_FFFF);
		send_request(32'h0000_0000);
		drain_results();
	endtask

	// With a zero window only stamps in the future survive compaction.
	task automatic test_zero_window();
		write_reg(REG_WINDOW, 16'd0);
		write_reg(REG_LIMIT, 16'hFFFF);
		send_request(32'd5);
		send_request(32'd5);
		send_request(32'd4);
		send_request(32'd6);
		drain_results();
	endtask

	// A zero limit refuses everything; a limit of one lets the log hold a single stamp.
	task automatic test_zero_limit();
		write_reg(REG_LIMIT, 16'd0);
		send_request(32'd7);
		send_request(32'd8);
		drain_results();
		write_reg(REG_LIMIT, 16'd1);
		send_request(32'd9);
		send_request(32'd9);
		drain_results();
	endtask

	// Writes to the unused indexes must leave window and limit alone: with a
	// window of 2 and a limit of 1 the first item is refused, the next one
	// admitted once the old stamp ages out.
	task automatic test_ignored_index();
		write_reg(REG_WINDOW, 16'd2);
		write_reg(REG_SPARE_2, 16'hFFFF);
		write_reg(REG_SPARE_3, 16'h0000);
		send_request(32'd10);
		send_request(32'd11);
		drain_results();
	endtask

	// Fills the log to capacity under a limit far above it and under a limit
	// one above it. The first request of the second round comes after every
	// earlier stamp has aged out.
	task automatic test_capacity_cap();
		logic [STAMP_W-1:0] base;
		base = $urandom;
		write_reg(REG_WINDOW, 16'hFFFF);
		write_reg(REG_LIMIT, 16'hFFFF);
		for (int i = 0; i < LOG_DEPTH + 4; i++)
			send_request(base + $urandom_range(0, 200));
		drain_results();
		write_reg(REG_LIMIT, 16'(LOG_DEPTH + 1));
		base = base + 32'd70000;
		for (int i = 0; i < LOG_DEPTH + 4; i++)
			send_request(base + $urandom_range(0, 200));
		drain_results();
	endtask

	function automatic logic [CFG_W-1:0] pick_window();
		case ($urandom_range(0, 7))
			0:       return 16'd0;
			1:       return 16'd1;
			2:       return 16'hFFFF;
			3:       return 16'd60;
			default: return 16'($urandom_range(2, 500));
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_limit();
		case ($urandom_range(0, 7))
			0:       return 16'd0;
			1:       return 16'd1;
			2:       return 16'(LOG_DEPTH);
			3:       return 16'(LOG_DEPTH + 1);
			4:       return 16'hFFFF;
			default: return 16'($urandom_range(2, 70));
		endcase
	endfunction

	// Random traffic in phases, each under fresh register values. Time mostly
	// moves forward in steps sized so that the log fills and drains around
	// the limit; a few items go back in time, jump by half the clock range,
	// or carry an arbitrary value. The last phases run without idling.
	task automatic test_random_traffic();
		localparam int PHASES      = 12;
		localparam int PHASE_ITEMS = 125;
		logic [STAMP_W-1:0] clock_base;
		int                 lim_eff;
		int                 span;
		for (int p = 0; p < PHASES; p++) begin
			if (p >= PHASES - 2)
				idle_enabled = 1'b0;
			write_reg(REG_WINDOW, pick_window());
			write_reg(REG_LIMIT, pick_limit());
			if ($urandom_range(0, 3) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, 16'($urandom));
			clock_base = $urandom;
			lim_eff = (limit_cfg == 0) ? 1 : (int'(limit_cfg) > LOG_DEPTH ? LOG_DEPTH : int'(limit_cfg));
			span = (2 * int'(window_cfg)) / lim_eff + 1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				case ($urandom_range(0, 19))
					0, 1:    send_request($urandom);
					2:       send_request(clock_base - $urandom_range(1, int'(window_cfg) + 1));
					3: begin
						clock_base = clock_base + 32'h8000_0000 + $urandom_range(0, 3);
						send_request(clock_base);
					end
					default: begin
						clock_base = clock_base + $urandom_range(0, span);
						send_request(clock_base);
					end
				endcase
				// Now and then the sender waits for the block to run dry.
				if ($urandom_range(0, 99) == 0)
					drain_results();
			end
			drain_results();
		end
	endtask

	// Receiver side: random stall bursts while idling is on.
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && idle_enabled && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Compares every accepted result item with the oldest prediction.
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_verdicts.size() == 0) begin
				$error("result item with no request waiting: admitted=%0d events_in_window=%0d",
					admitted, events_in_window);
				fail_count++;
			end else begin
				want = pending_verdicts.pop_front();
				if (admitted !== want.admitted) begin
					$error("admitted: expected %0d, got %0d", want.admitted, admitted);
					fail_count++;
				end
				if (events_in_window !== want.events) begin
					$error("events_in_window: expected %0d, got %0d", want.events, events_in_window);
					fail_count++;
				end
			end
		end
	end

	// Guard against a hung handshake.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int waited;
		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_index    <= REG_WINDOW;
		cfg_wdata    <= '0;
		in_valid     <= 1'b0;
		now_seconds  <= '0;
		window_cfg   = WINDOW_RESET;
		limit_cfg    = LIMIT_RESET;
		fail_count   = 0;
		cycle_count  = 0;
		idle_enabled = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_future_and_wraparound();
		test_zero_window();
		test_zero_limit();
		test_ignored_index();
		test_capacity_cap();
		test_random_traffic();

		// Final drain with its own bound, so a lost result shows up as such.
		in_valid <= 1'b0;
		waited = 0;
		while (pending_verdicts.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (pending_verdicts.size() != 0) begin
			$error("%0d predicted results never arrived", pending_verdicts.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
+incdir+hw/rtl
hw/rtl/swrl_pkg.sv
hw/rtl/swrl_ctrl.sv
hw/rtl/swrl_dp.sv
hw/rtl/sliding_window_rate_limiter.sv
hw/rtl/swrl_chk.sv
bench/tb_sliding_window_rate_limiter.sv
